[rtl/multichannel_3x3_conv_line_buffer_macros.svh]
// Assertion helpers shared by the line buffer RTL.
// All checks sample on clk_i and are off while rst_ni is low.
`ifndef MULTICHANNEL_3X3_CONV_LINE_BUFFER_MACROS_SVH
`define MULTICHANNEL_3X3_CONV_LINE_BUFFER_MACROS_SVH

// Concurrent check of a property.
`define CMLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define CMLB_ASSERT_NEXT(lbl, cond, res, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (res)) else $error(msg);

`endif

[rtl/cmlb_pkg.sv]
`timescale 1ns / 1ps
package cmlb_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int HALF        = KERNEL_SIZE >> 1;
  localparam int MAX_HEIGHT  = 4096;

  localparam int PIX_W    = 16;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 5;
  localparam int PROD_W   = PIX_W + COEF_W;
  localparam int TAP_W    = PROD_W + 2;
  localparam int ACC_W    = 36;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_COEFF  = 2'd0,
    MODE_PIXEL  = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]               mode;
    logic [CIDX_W-1:0]        coeff_index;
    logic signed [COEF_W-1:0] coeff_value;
    logic signed [PIX_W-1:0]  pix_ch0;
    logic signed [PIX_W-1:0]  pix_ch1;
    logic signed [PIX_W-1:0]  pix_ch2;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] out_value;
    logic                    out_last;
  } out_item_t;

  // Per-tap channel sums of one pixel beat.
  typedef struct packed {
    logic [TAPS-1:0][TAP_W-1:0] m;
  } taps_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
  } cfg_t;

endpackage

[rtl/cmlb_front.sv]
`timescale 1ns / 1ps
module cmlb_front #(
  parameter int CHANNELS = 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  cmlb_pkg::in_item_t     in_data_i,
  input  logic [cmlb_pkg::QCW-1:0] q_count_i,
  output logic                   tap_valid_o,
  output cmlb_pkg::taps_t        taps_o
);

  localparam int NCOEF = CHANNELS * cmlb_pkg::TAPS;
  localparam int CIW   = $clog2(NCOEF);

  logic signed [cmlb_pkg::COEF_W-1:0] coeff_q [NCOEF];
  logic signed [cmlb_pkg::PIX_W-1:0]  pix [CHANNELS];
  logic signed [cmlb_pkg::PROD_W-1:0] prod_d [CHANNELS][cmlb_pkg::TAPS];
  logic signed [cmlb_pkg::PROD_W-1:0] prod_q [CHANNELS][cmlb_pkg::TAPS];
  logic s1_valid_q, s1_zero_q, s2_valid_q;
  cmlb_pkg::taps_t taps_d, taps_q;
  logic accept, is_pix, is_flush, is_coeff;
  logic [cmlb_pkg::QCW:0] occ;

  // Credit against the queue: count beats still in the two front stages.
  assign occ    = {1'b0, q_count_i} + (cmlb_pkg::QCW+1)'(s1_valid_q)
                + (cmlb_pkg::QCW+1)'(s2_valid_q);
  assign full   = (occ >= (cmlb_pkg::QCW+1)'(cmlb_pkg::QDEPTH));
  assign accept = push && !full;

  assign is_coeff = (in_data_i.mode == cmlb_pkg::MODE_COEFF);
  assign is_pix   = (in_data_i.mode == cmlb_pkg::MODE_PIXEL);
  assign is_flush = (in_data_i.mode == cmlb_pkg::MODE_FLUSH);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (c == 0) begin
        pix[c] = in_data_i.pix_ch0;
      end else if (c == 1) begin
        pix[c] = in_data_i.pix_ch1;
      end else begin
        pix[c] = in_data_i.pix_ch2;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      for (int k = 0; k < cmlb_pkg::TAPS; k++) begin
        prod_d[c][k] = pix[c] * coeff_q[c*cmlb_pkg::TAPS + k];
      end
    end
  end

  always_comb begin
    logic signed [cmlb_pkg::TAP_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < cmlb_pkg::TAPS; k++) begin
      acc = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        acc = acc + cmlb_pkg::TAP_W'(prod_q[c][k]);
      end
      taps_d.m[k] = s1_zero_q ? '0 : acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coeff_q[i] <= '0;
      end
    end else if (accept && is_coeff &&
                 (in_data_i.coeff_index < cmlb_pkg::CIDX_W'(NCOEF))) begin
      coeff_q[in_data_i.coeff_index[CIW-1:0]] <= in_data_i.coeff_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept && (is_pix || is_flush);
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    s1_zero_q <= is_flush;
    taps_q    <= taps_d;
  end

  assign tap_valid_o = s2_valid_q;
  assign taps_o      = taps_q;

endmodule

[rtl/cmlb_fifo.sv]
`timescale 1ns / 1ps
`include "multichannel_3x3_conv_line_buffer_macros.svh"
module cmlb_fifo (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  cmlb_pkg::taps_t          data_i,
  input  logic                     pop_i,
  output logic                     valid_o,
  output cmlb_pkg::taps_t          data_o,
  output logic [cmlb_pkg::QCW-1:0] count_o
);

  cmlb_pkg::taps_t mem_q [cmlb_pkg::QDEPTH];
  logic [cmlb_pkg::QAW-1:0] wr_q, rd_q;
  logic [cmlb_pkg::QCW-1:0] count_q;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      count_q <= count_q + cmlb_pkg::QCW'(push_i) - cmlb_pkg::QCW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `CMLB_ASSERT(a_q_no_overflow, push_i |-> (count_q != cmlb_pkg::QCW'(cmlb_pkg::QDEPTH)), "queue overflow: front credit broken")
  `CMLB_ASSERT(a_q_no_underflow, pop_i |-> (count_q != '0), "pop from empty queue")

endmodule

[rtl/cmlb_back.sv]
`timescale 1ns / 1ps
`include "multichannel_3x3_conv_line_buffer_macros.svh"
module cmlb_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmlb_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  cmlb_pkg::taps_t     q_data_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output cmlb_pkg::out_item_t out_data_o
);

  localparam int LINE_LEN = MAX_WIDTH - 2;
  localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int DEPTH = 1 << AW;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int NW = $clog2(MAX_WIDTH * cmlb_pkg::MAX_HEIGHT + MAX_WIDTH + 1);
  localparam int AC = cmlb_pkg::ACC_W;

  // Derived frame geometry, refreshed every cycle from the config registers.
  logic [WW-1:0] w_q, wm1_q, wm2_q;
  logic [NW-1:0] disc_q, lastn_q;
  logic [WW-1:0] w_d, wm1_d, wm2_d;
  logic [NW-1:0] disc_d, lastn_d;

  logic [2*AC-1:0] line_mem [DEPTH];
  logic [2*AC-1:0] rdata_q, wdata;
  logic [AW-1:0]   wp_q, wa, raddr;
  logic [WW-1:0]   fill_q;
  logic [CW-1:0]   col_q;
  logic [NW-1:0]   n_q;

  logic signed [AC-1:0] h00_q, h01_q, h10_q, h11_q, h20_q, h21_q;
  logic signed [AC-1:0] h00_d, h01_d, h10_d, h11_d, h20_d, h21_d;
  logic signed [AC-1:0] result, ins0, ins1, r0, r1;
  logic signed [AC-1:0] mx [cmlb_pkg::TAPS];

  logic b_valid_q, b_fire, a_pop, bypass;
  cmlb_pkg::taps_t b_taps_q;
  logic first, last, emit, final_px;

  logic            out_valid_q;
  logic signed [AC-1:0] out_val_q;
  logic            out_last_q;

  always_comb begin
    int wi, hi;
    wi = int'(cfg_i.width);
    hi = int'(cfg_i.height);
    if (wi < 3) wi = 3;
    if (wi > MAX_WIDTH) wi = MAX_WIDTH;
    if (hi < 1) hi = 1;
    if (hi > cmlb_pkg::MAX_HEIGHT) hi = cmlb_pkg::MAX_HEIGHT;
    w_d     = WW'(wi);
    wm1_d   = WW'(wi - 1);
    wm2_d   = WW'(wi - 2);
    disc_d  = NW'(wi * cmlb_pkg::HALF + cmlb_pkg::HALF);
    lastn_d = NW'(wi * hi + wi * cmlb_pkg::HALF + cmlb_pkg::HALF - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= '0;
      wm1_q   <= '0;
      wm2_q   <= '0;
      disc_q  <= '0;
      lastn_q <= '0;
    end else begin
      w_q     <= w_d;
      wm1_q   <= wm1_d;
      wm2_q   <= wm2_d;
      disc_q  <= disc_d;
      lastn_q <= lastn_d;
    end
  end

  always_comb begin
    for (int k = 0; k < cmlb_pkg::TAPS; k++) begin
      mx[k] = AC'($signed(b_taps_q.m[k]));
    end
  end

  // Entries older than the pushes since frame start read as zero.
  assign r0 = (fill_q >= wm2_q) ? $signed(rdata_q[AC-1:0])    : '0;
  assign r1 = (fill_q >= wm2_q) ? $signed(rdata_q[2*AC-1:AC]) : '0;

  assign first = (col_q == '0);
  assign last  = (WW'(col_q) >= wm1_q) || (w_q == '0);

  always_comb begin
    result = h21_q + (first ? '0 : mx[8]);
    h21_d  = h20_q + mx[7];
    h20_d  = r1 + (last ? '0 : mx[6]);
    ins1   = h11_q + (first ? '0 : mx[5]);
    h11_d  = h10_q + mx[4];
    h10_d  = r0 + (last ? '0 : mx[3]);
    ins0   = h01_q + (first ? '0 : mx[2]);
    h01_d  = h00_q + mx[1];
    h00_d  = last ? '0 : mx[0];
  end

  assign emit     = (n_q >= disc_q);
  assign final_px = emit && (n_q >= lastn_q);
  assign b_fire   = b_valid_q && (!emit || !out_valid_q || pop);
  assign a_pop    = q_valid_i && (!b_valid_q || b_fire);
  assign q_pop_o  = a_pop;

  assign wdata  = {ins1, ins0};
  assign wa     = b_fire ? wp_q + 1'b1 : wp_q;
  assign raddr  = wa - wm2_q[AW-1:0];
  assign bypass = b_fire && (raddr == wp_q);

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      line_mem[wp_q] <= wdata;
    end
    if (a_pop) begin
      rdata_q  <= bypass ? wdata : line_mem[raddr];
      b_taps_q <= q_data_i;
    end
    if (b_fire && emit) begin
      out_val_q  <= result;
      out_last_q <= final_px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      wp_q        <= '0;
      fill_q      <= '0;
      col_q       <= '0;
      n_q         <= '0;
      h00_q <= '0; h01_q <= '0; h10_q <= '0;
      h11_q <= '0; h20_q <= '0; h21_q <= '0;
    end else begin
      if (a_pop) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (b_fire) begin
        wp_q <= wp_q + 1'b1;
        if (final_px) begin
          // Frame done: drop all partial sums and restart the counters.
          fill_q <= '0;
          col_q  <= '0;
          n_q    <= '0;
          h00_q <= '0; h01_q <= '0; h10_q <= '0;
          h11_q <= '0; h20_q <= '0; h21_q <= '0;
        end else begin
          if (fill_q < WW'(LINE_LEN)) begin
            fill_q <= fill_q + 1'b1;
          end
          col_q <= last ? '0 : col_q + 1'b1;
          n_q   <= n_q + 1'b1;
          h00_q <= h00_d; h01_q <= h01_d; h10_q <= h10_d;
          h11_q <= h11_d; h20_q <= h20_d; h21_q <= h21_d;
        end
      end
    end
  end

  assign empty                = !out_valid_q;
  assign out_data_o.out_value = out_val_q;
  assign out_data_o.out_last  = out_last_q;

  `CMLB_ASSERT_NEXT(a_frame_restart, b_fire && final_px, (n_q == '0) && (col_q == '0) && (fill_q == '0), "counters not cleared after last pixel")
  `CMLB_ASSERT(a_fill_bound, fill_q <= WW'(LINE_LEN), "fill count beyond line length")

endmodule

[rtl/multichannel_3x3_conv_line_buffer.sv]
// Each pixel or flush beat passes product, tap-sum, queue, hold and output registers.
// Throughput: one beat per cycle while full is low, set by the single-port-write line store.
// The first width+1 beats of a frame give no result; flush beats drain the last width+1.
// Reset (rst_ni, async low): coefficients zero, width 640, height 480, counters clear.
// Line store contents are not cleared; a fill count masks stale entries, no clearing pass.
`timescale 1ns / 1ps
module multichannel_3x3_conv_line_buffer #(
  parameter int CHANNELS  = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input beats
  input  logic                            push,
  output logic                            full,
  input  cmlb_pkg::in_item_t              in_data_i,
  // Result beats
  output logic                            empty,
  input  logic                            pop,
  output cmlb_pkg::out_item_t             out_data_o,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [cmlb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cmlb_pkg::CFG_W-1:0]      cfg_data_i
);

  // Config registers; a written value passes these and then the back end's geometry registers.
  logic [cmlb_pkg::WIDTH_W-1:0]  width_q;
  logic [cmlb_pkg::HEIGHT_W-1:0] height_q;
  cmlb_pkg::cfg_t                cfg;

  // Front to back queue of per-tap sums.
  logic                     tap_valid, q_valid, q_pop;
  cmlb_pkg::taps_t          taps, q_data;
  logic [cmlb_pkg::QCW-1:0] q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cmlb_pkg::WIDTH_W'(640);
      height_q <= cmlb_pkg::HEIGHT_W'(480);
    end else if (cfg_we_i) begin
      case (cmlb_pkg::cfg_idx_e'(cfg_idx_i))
        cmlb_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[cmlb_pkg::WIDTH_W-1:0];
        cmlb_pkg::CFG_HEIGHT: height_q <= cfg_data_i[cmlb_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.width  = width_q;
  assign cfg.height = height_q;

  // Front: take beats, load coefficients, multiply and sum channels per tap.
  cmlb_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_data_i   (in_data_i),
    .q_count_i   (q_count),
    .tap_valid_o (tap_valid),
    .taps_o      (taps)
  );

  // Short queue decouples the multiplier pipe from the line store.
  cmlb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tap_valid),
    .data_i  (taps),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .count_o (q_count)
  );

  // Back: hold registers, line store of partial sums, frame counters, output register.
  cmlb_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

endmodule
